[rtl/core/hssc_pkg.sv]
// Shared constants, register map and commutation tables for the hall six-step commutator
// No dependencies; used by the channel interfaces and the top level
`default_nettype none

package hssc_pkg;

    // payload widths fixed by the item format
    localparam int unsigned DUTY_W     = 7;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned PULSES_W   = 16;
    localparam int unsigned THROTTLE_W = 12;
    localparam int unsigned VOTE_W     = 2;
    localparam int unsigned LEGS_W     = 6;

    // throttle scaling (x*100 + 2047) / 4095
    localparam int unsigned SCALED_W     = 19;
    localparam int unsigned SCALE_SHIFT  = 12;
    localparam logic [SCALED_W-1:0] THROTTLE_SCALE = 19'd100;
    localparam logic [SCALED_W-1:0] ROUND_BIAS     = 19'd2047;
    localparam logic [SCALED_W-1:0] THROTTLE_FULL  = 19'd4095;

    // configuration register map
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam logic [1:0] REG_DUTY_MAX       = 2'd0;
    localparam logic [1:0] REG_DUTY_CUTOFF    = 2'd1;
    localparam logic [1:0] REG_VOTE_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_BLANK_TIME     = 2'd3;

    // register reset values
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST       = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_CUTOFF_RST    = 7'd2;
    localparam logic [VOTE_W-1:0]  VOTE_THRESHOLD_RST = 2'd1;
    localparam logic [TICKS_W-1:0] BLANK_TIME_RST     = 16'd5;

    // item kinds
    localparam logic KIND_CONTROL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // step for an invalid hall code
    localparam logic [STEP_W-1:0] STEP_OFF = 3'd6;

    // hall code (A bit 0, B bit 1, C bit 2) to commutation step
    function automatic logic [STEP_W-1:0] step_of_code(input logic [2:0] code);
        logic [STEP_W-1:0] step;
        case (code)
            3'd3:    step = 3'd0;
            3'd2:    step = 3'd1;
            3'd6:    step = 3'd2;
            3'd4:    step = 3'd3;
            3'd5:    step = 3'd4;
            3'd1:    step = 3'd5;
            default: step = STEP_OFF;
        endcase
        return step;
    endfunction

    // switches driven per step: bit5 U high, bit4 U low, bit3 V high,
    // bit2 V low, bit1 W high, bit0 W low
    function automatic logic [LEGS_W-1:0] legs_of_step(input logic [STEP_W-1:0] step);
        logic [LEGS_W-1:0] legs;
        case (step)
            3'd0:    legs = 6'h09;
            3'd1:    legs = 6'h18;
            3'd2:    legs = 6'h12;
            3'd3:    legs = 6'h06;
            3'd4:    legs = 6'h24;
            3'd5:    legs = 6'h21;
            default: legs = 6'h00;
        endcase
        return legs;
    endfunction

endpackage

`default_nettype wire

[rtl/core/hssc_if.sv]
// Valid/ready channel interfaces for command items and result items
// Depends on hssc_pkg for payload widths
`default_nettype none

interface hssc_cmd_if #(
    parameter int unsigned HALL_READS = 3
);
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [HALL_READS-1:0]             hall_a_reads;
    logic [HALL_READS-1:0]             hall_b_reads;
    logic [HALL_READS-1:0]             hall_c_reads;
    logic [hssc_pkg::THROTTLE_W-1:0]   throttle_sample;

    modport source (
        output valid, kind, hall_a_reads, hall_b_reads, hall_c_reads, throttle_sample,
        input  ready
    );
    modport sink (
        input  valid, kind, hall_a_reads, hall_b_reads, hall_c_reads, throttle_sample,
        output ready
    );
endinterface

interface hssc_res_if;
    logic                            valid;
    logic                            ready;
    logic [hssc_pkg::DUTY_W-1:0]     u_high_duty;
    logic [hssc_pkg::DUTY_W-1:0]     u_low_duty;
    logic [hssc_pkg::DUTY_W-1:0]     v_high_duty;
    logic [hssc_pkg::DUTY_W-1:0]     v_low_duty;
    logic [hssc_pkg::DUTY_W-1:0]     w_high_duty;
    logic [hssc_pkg::DUTY_W-1:0]     w_low_duty;
    logic [hssc_pkg::STEP_W-1:0]     step_index;
    logic [hssc_pkg::TICKS_W-1:0]    blank_ticks;
    logic [hssc_pkg::PULSES_W-1:0]   interval_pulses;
    logic                            interval_done;

    modport source (
        output valid, u_high_duty, u_low_duty, v_high_duty, v_low_duty,
               w_high_duty, w_low_duty, step_index, blank_ticks,
               interval_pulses, interval_done,
        input  ready
    );
    modport sink (
        input  valid, u_high_duty, u_low_duty, v_high_duty, v_low_duty,
               w_high_duty, w_low_duty, step_index, blank_ticks,
               interval_pulses, interval_done,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/hall_six_step_commutator_unit.sv]
// Top level of the hall six-step commutator: input register, decode/scale logic, result register
// Depends on hssc_pkg and the channel interfaces in hssc_if.sv
`default_nettype none

// Takes one item per clock unless the result side stalls, and returns one result per item:
// the item is captured in an input register, then hall voting, throttle scaling, the step
// table and the pulse counter update are done in one pass of logic
// that loads the result register. Motor state (step, duty, pulse count) is updated as
// each item leaves the input register, so items may follow back to back. A stalled
// result holds in the result register while the input register keeps one more item.
// Configuration goes through the APB port at byte addresses 0, 4, 8, 12 (duty_max,
// duty_cutoff, vote_threshold, blank_time) and should be written only while no item is
// in flight. A tick item returns the pulse count of the finished interval and clears it.
module hall_six_step_commutator_unit #(
    parameter int unsigned HALL_READS = 3,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hssc_cmd_if.sink                            cmd,
    hssc_res_if.source                          res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hssc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hssc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hssc_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int unsigned VOTE_CNT_W = $clog2(HALL_READS + 1);

    // configuration registers
    logic [hssc_pkg::DUTY_W-1:0]  duty_max_reg;
    logic [hssc_pkg::DUTY_W-1:0]  duty_cutoff_reg;
    logic [hssc_pkg::VOTE_W-1:0]  vote_threshold_reg;
    logic [hssc_pkg::TICKS_W-1:0] blank_time_reg;
    logic                         cfg_write;
    logic [1:0]                   cfg_index;

    // input register
    logic                              s1_valid_reg;
    logic                              s1_kind_reg;
    logic [HALL_READS-1:0]             s1_a_reg;
    logic [HALL_READS-1:0]             s1_b_reg;
    logic [HALL_READS-1:0]             s1_c_reg;
    logic [hssc_pkg::THROTTLE_W-1:0]   s1_throttle_reg;

    // motor state
    logic [hssc_pkg::STEP_W-1:0] current_step_reg;
    logic [hssc_pkg::STEP_W-1:0] current_step_next;
    logic [hssc_pkg::DUTY_W-1:0] current_duty_reg;
    logic [hssc_pkg::DUTY_W-1:0] current_duty_next;
    logic [COUNT_BITS-1:0]       pulse_count_reg;
    logic [COUNT_BITS-1:0]       pulse_count_next;

    // result register
    logic                           res_valid_reg;
    logic [hssc_pkg::LEGS_W-1:0]    res_legs_reg;
    logic [hssc_pkg::LEGS_W-1:0]    res_legs_next;
    logic [hssc_pkg::DUTY_W-1:0]    res_duty_reg;
    logic [hssc_pkg::STEP_W-1:0]    res_step_reg;
    logic [hssc_pkg::TICKS_W-1:0]   res_blank_reg;
    logic [hssc_pkg::TICKS_W-1:0]   res_blank_next;
    logic [hssc_pkg::PULSES_W-1:0]  res_pulses_reg;
    logic [hssc_pkg::PULSES_W-1:0]  res_pulses_next;
    logic                           res_done_reg;

    // handshake
    logic res_load;
    logic cmd_take;

    // datapath
    logic [VOTE_CNT_W-1:0]          cnt_a;
    logic [VOTE_CNT_W-1:0]          cnt_b;
    logic [VOTE_CNT_W-1:0]          cnt_c;
    logic [2:0]                     hall_code;
    logic [hssc_pkg::SCALED_W-1:0]  scaled;
    logic [hssc_pkg::DUTY_W-1:0]    quot_est;
    logic [hssc_pkg::SCALED_W-1:0]  quot_est_mul;
    logic [hssc_pkg::SCALED_W-1:0]  scaled_rem;
    logic [hssc_pkg::DUTY_W-1:0]    duty_raw;
    logic [hssc_pkg::DUTY_W-1:0]    duty_clamped;
    logic [hssc_pkg::DUTY_W-1:0]    duty_final;
    logic [hssc_pkg::STEP_W-1:0]    new_step;
    logic                           step_changed;
    logic [31:0]                    pulse_ext;

    // apb access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[hssc_pkg::PADDR_W-1:2];

    always_comb
    begin
        case (cfg_index)
            hssc_pkg::REG_DUTY_MAX:       prdata = 32'(duty_max_reg);
            hssc_pkg::REG_DUTY_CUTOFF:    prdata = 32'(duty_cutoff_reg);
            hssc_pkg::REG_VOTE_THRESHOLD: prdata = 32'(vote_threshold_reg);
            hssc_pkg::REG_BLANK_TIME:     prdata = 32'(blank_time_reg);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_max_reg       <= hssc_pkg::DUTY_MAX_RST;
            duty_cutoff_reg    <= hssc_pkg::DUTY_CUTOFF_RST;
            vote_threshold_reg <= hssc_pkg::VOTE_THRESHOLD_RST;
            blank_time_reg     <= hssc_pkg::BLANK_TIME_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hssc_pkg::REG_DUTY_MAX:       duty_max_reg <= pwdata[hssc_pkg::DUTY_W-1:0];
                hssc_pkg::REG_DUTY_CUTOFF:    duty_cutoff_reg <= pwdata[hssc_pkg::DUTY_W-1:0];
                hssc_pkg::REG_VOTE_THRESHOLD: vote_threshold_reg <= pwdata[hssc_pkg::VOTE_W-1:0];
                hssc_pkg::REG_BLANK_TIME:     blank_time_reg <= pwdata[hssc_pkg::TICKS_W-1:0];
                default:                      ;
            endcase
        end
    end

    // pipeline flow: result register frees up when empty or taken
    assign res_load  = s1_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || !res_valid_reg || res.ready;
    assign cmd_take  = cmd.valid && cmd.ready;

    // hall sensor voting
    assign cnt_a = VOTE_CNT_W'($countones(s1_a_reg));
    assign cnt_b = VOTE_CNT_W'($countones(s1_b_reg));
    assign cnt_c = VOTE_CNT_W'($countones(s1_c_reg));
    assign hall_code[0] = 32'(cnt_a) >= 32'(vote_threshold_reg);
    assign hall_code[1] = 32'(cnt_b) >= 32'(vote_threshold_reg);
    assign hall_code[2] = 32'(cnt_c) >= 32'(vote_threshold_reg);

    // throttle scaling: quotient by 4095 is n>>12 or one more
    assign scaled       = hssc_pkg::SCALED_W'(s1_throttle_reg) * hssc_pkg::THROTTLE_SCALE
                          + hssc_pkg::ROUND_BIAS;
    assign quot_est     = scaled[hssc_pkg::SCALED_W-1:hssc_pkg::SCALE_SHIFT];
    assign quot_est_mul = (hssc_pkg::SCALED_W'(quot_est) << hssc_pkg::SCALE_SHIFT)
                          - hssc_pkg::SCALED_W'(quot_est);
    assign scaled_rem   = scaled - quot_est_mul;
    assign duty_raw     = quot_est + ((scaled_rem >= hssc_pkg::THROTTLE_FULL) ? 7'd1 : 7'd0);

    // clamp then cutoff
    assign duty_clamped = (duty_raw >= duty_max_reg) ? duty_max_reg : duty_raw;
    assign duty_final   = (duty_clamped <= duty_cutoff_reg) ? '0 : duty_clamped;

    // step decode and change detection
    assign new_step     = hssc_pkg::step_of_code(hall_code);
    assign step_changed = new_step != current_step_reg;
    assign pulse_ext    = 32'(pulse_count_reg);

    // next state and result for the item leaving the input register
    always_comb
    begin
        current_step_next = current_step_reg;
        current_duty_next = current_duty_reg;
        pulse_count_next  = pulse_count_reg;
        res_legs_next     = hssc_pkg::legs_of_step(current_step_reg);
        res_blank_next    = '0;
        res_pulses_next   = '0;
        if (s1_kind_reg == hssc_pkg::KIND_TICK)
        begin
            res_pulses_next  = pulse_ext[hssc_pkg::PULSES_W-1:0];
            pulse_count_next = '0;
        end
        else
        begin
            current_step_next = new_step;
            current_duty_next = duty_final;
            res_legs_next     = hssc_pkg::legs_of_step(new_step);
            if (step_changed)
            begin
                res_blank_next = blank_time_reg;
                if (pulse_count_reg != {COUNT_BITS{1'b1}})
                begin
                    pulse_count_next = pulse_count_reg + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            current_step_reg <= '0;
            current_duty_reg <= '0;
            pulse_count_reg  <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (res_load)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (res_load)
            begin
                res_valid_reg    <= 1'b1;
                current_step_reg <= current_step_next;
                current_duty_reg <= current_duty_next;
                pulse_count_reg  <= pulse_count_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // input item capture
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_kind_reg     <= cmd.kind;
            s1_a_reg        <= cmd.hall_a_reads;
            s1_b_reg        <= cmd.hall_b_reads;
            s1_c_reg        <= cmd.hall_c_reads;
            s1_throttle_reg <= cmd.throttle_sample;
        end
    end

    // result payload capture
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_legs_reg   <= res_legs_next;
            res_duty_reg   <= current_duty_next;
            res_step_reg   <= current_step_next;
            res_blank_reg  <= res_blank_next;
            res_pulses_reg <= res_pulses_next;
            res_done_reg   <= s1_kind_reg;
        end
    end

    // result item drive
    assign res.valid           = res_valid_reg;
    assign res.u_high_duty     = res_legs_reg[5] ? res_duty_reg : '0;
    assign res.u_low_duty      = res_legs_reg[4] ? res_duty_reg : '0;
    assign res.v_high_duty     = res_legs_reg[3] ? res_duty_reg : '0;
    assign res.v_low_duty      = res_legs_reg[2] ? res_duty_reg : '0;
    assign res.w_high_duty     = res_legs_reg[1] ? res_duty_reg : '0;
    assign res.w_low_duty      = res_legs_reg[0] ? res_duty_reg : '0;
    assign res.step_index      = res_step_reg;
    assign res.blank_ticks     = res_blank_reg;
    assign res.interval_pulses = res_pulses_reg;
    assign res.interval_done   = res_done_reg;

endmodule

`default_nettype wire

[dv/hall_six_step_commutator_unit_tb.sv]
// Self-checking testbench for hall_six_step_commutator_unit: hall votes, throttle scaling,
// step drive, blanking and the interval pulse counter, under several register settings
// Depends on hssc_pkg, the channel interfaces in hssc_if.sv and the top level RTL

module hall_six_step_commutator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hssc_pkg::*;

    localparam int unsigned HALL_READS     = 3;
    localparam int unsigned COUNT_BITS     = 16;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS    = 190;
    localparam int unsigned BURST_ITEMS    = 16;

    // one command item as it crosses the input channel
    typedef struct packed {
        logic                  kind;
        logic [HALL_READS-1:0] a_reads;
        logic [HALL_READS-1:0] b_reads;
        logic [HALL_READS-1:0] c_reads;
        logic [THROTTLE_W-1:0] throttle;
    } hall_sample_t;

    // one result item: six switch duties, step, blanking and interval report
    typedef struct packed {
        logic [DUTY_W-1:0]   u_high;
        logic [DUTY_W-1:0]   u_low;
        logic [DUTY_W-1:0]   v_high;
        logic [DUTY_W-1:0]   v_low;
        logic [DUTY_W-1:0]   w_high;
        logic [DUTY_W-1:0]   w_low;
        logic [STEP_W-1:0]   step;
        logic [TICKS_W-1:0]  blank;
        logic [PULSES_W-1:0] pulses;
        logic                done;
    } drive_result_t;

    // commutation predictor plus the queue of drive results still owed by the block
    class commutation_scoreboard;
        logic [DUTY_W-1:0]     duty_max;
        logic [DUTY_W-1:0]     duty_cutoff;
        logic [VOTE_W-1:0]     vote_threshold;
        logic [TICKS_W-1:0]    blank_time;
        logic [STEP_W-1:0]     step_now;
        logic [COUNT_BITS-1:0] pulse_count;
        logic [DUTY_W-1:0]     duty_now;
        drive_result_t         pending_drive[$];
        int unsigned           items_noted;
        int unsigned           ticks_noted;
        int unsigned           changes_noted;
        int unsigned           results_checked;
        int unsigned           mismatches;

        function new();
            duty_max       = DUTY_MAX_RST;
            duty_cutoff    = DUTY_CUTOFF_RST;
            vote_threshold = VOTE_THRESHOLD_RST;
            blank_time     = BLANK_TIME_RST;
            step_now       = '0;
            pulse_count    = '0;
            duty_now       = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] word);
            case (idx)
                REG_DUTY_MAX:       duty_max       = word[DUTY_W-1:0];
                REG_DUTY_CUTOFF:    duty_cutoff    = word[DUTY_W-1:0];
                REG_VOTE_THRESHOLD: vote_threshold = word[VOTE_W-1:0];
                default:            blank_time     = word[TICKS_W-1:0];
            endcase
        endfunction

        // hall code (A bit 0, B bit 1, C bit 2) to commutation step
        function logic [STEP_W-1:0] step_for_code(logic [2:0] code);
            case (code)
                3'd3:    return 3'd0;
                3'd2:    return 3'd1;
                3'd6:    return 3'd2;
                3'd4:    return 3'd3;
                3'd5:    return 3'd4;
                3'd1:    return 3'd5;
                default: return STEP_OFF;
            endcase
        endfunction

        // each valid step drives one upper and one lower switch at the duty; the off step drives none
        function drive_result_t drive_of(logic [STEP_W-1:0] step, logic [DUTY_W-1:0] duty);
            drive_result_t r;
            r = '0;
            r.step = step;
            case (step)
                3'd0:    begin r.v_high = duty; r.w_low = duty; end
                3'd1:    begin r.v_high = duty; r.u_low = duty; end
                3'd2:    begin r.w_high = duty; r.u_low = duty; end
                3'd3:    begin r.w_high = duty; r.v_low = duty; end
                3'd4:    begin r.u_high = duty; r.v_low = duty; end
                3'd5:    begin r.u_high = duty; r.w_low = duty; end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(hall_sample_t s);
            drive_result_t     want;
            logic [2:0]        code;
            logic [STEP_W-1:0] next_step;
            int unsigned       duty;
            int unsigned       x;
            items_noted++;
            if (s.kind == KIND_TICK) begin
                // report and clear the interval count, drive repeats
                want = drive_of(step_now, duty_now);
                want.pulses = pulse_count[PULSES_W-1:0];
                want.done = 1'b1;
                pulse_count = '0;
                ticks_noted++;
            end
            else begin
                // threshold vote per sensor, zero threshold sets every bit
                code[0] = ($countones(s.a_reads) >= vote_threshold);
                code[1] = ($countones(s.b_reads) >= vote_threshold);
                code[2] = ($countones(s.c_reads) >= vote_threshold);
                // rounded percent, clamp first, then cutoff
                x = s.throttle;
                duty = (x * 100 + 2047) / 4095;
                if (duty >= duty_max)
                    duty = duty_max;
                if (duty <= duty_cutoff)
                    duty = 0;
                duty_now = DUTY_W'(duty);
                next_step = step_for_code(code);
                want = drive_of(next_step, duty_now);
                if (next_step != step_now) begin
                    changes_noted++;
                    want.blank = blank_time;
                    if (pulse_count != '1)
                        pulse_count++;
                end
                step_now = next_step;
            end
            pending_drive.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: result %0d field %s mismatch: expected %0d, actual %0d",
                         $time, results_checked, name, want, got);
            end
        endfunction

        function void check_item(drive_result_t got);
            drive_result_t want;
            if (pending_drive.size() == 0) begin
                mismatches++;
                $display("%0t: result item with none expected: expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = pending_drive.pop_front();
            results_checked++;
            compare_field("u_high_duty", want.u_high, got.u_high);
            compare_field("u_low_duty", want.u_low, got.u_low);
            compare_field("v_high_duty", want.v_high, got.v_high);
            compare_field("v_low_duty", want.v_low, got.v_low);
            compare_field("w_high_duty", want.w_high, got.w_high);
            compare_field("w_low_duty", want.w_low, got.w_low);
            compare_field("step_index", want.step, got.step);
            compare_field("blank_ticks", want.blank, got.blank);
            compare_field("interval_pulses", want.pulses, got.pulses);
            compare_field("interval_done", want.done, got.done);
        endfunction

        function int unsigned outstanding();
            return pending_drive.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           quiet_cycles;
    int unsigned           seq_pos;
    bit                    seq_fwd;
    commutation_scoreboard sb;

    hssc_cmd_if #(.HALL_READS(HALL_READS)) cmd_ch();
    hssc_res_if                            res_ch();

    hall_six_step_commutator_unit #(
        .HALL_READS (HALL_READS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        res_ch.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // sample both channels, check results, note inputs, watch for a hang
    always @(posedge clk)
    begin
        drive_result_t got;
        hall_sample_t  seen;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.u_high = res_ch.u_high_duty;
                got.u_low  = res_ch.u_low_duty;
                got.v_high = res_ch.v_high_duty;
                got.v_low  = res_ch.v_low_duty;
                got.w_high = res_ch.w_high_duty;
                got.w_low  = res_ch.w_low_duty;
                got.step   = res_ch.step_index;
                got.blank  = res_ch.blank_ticks;
                got.pulses = res_ch.interval_pulses;
                got.done   = res_ch.interval_done;
                sb.check_item(got);
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                seen.kind     = cmd_ch.kind;
                seen.a_reads  = cmd_ch.hall_a_reads;
                seen.b_reads  = cmd_ch.hall_b_reads;
                seen.c_reads  = cmd_ch.hall_c_reads;
                seen.throttle = cmd_ch.throttle_sample;
                sb.note_item(seen);
            end
            if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
                quiet_cycles = 0;
            else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                             $time, quiet_cycles, sb.outstanding());
                    $display("hall_six_step_commutator_unit_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // drive one item, with random idle cycles ahead of it; called at a falling edge
    task automatic send_item(input hall_sample_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid           = 1'b0;
            cmd_ch.kind            = 1'($urandom);
            cmd_ch.hall_a_reads    = HALL_READS'($urandom);
            cmd_ch.hall_b_reads    = HALL_READS'($urandom);
            cmd_ch.hall_c_reads    = HALL_READS'($urandom);
            cmd_ch.throttle_sample = THROTTLE_W'($urandom);
            @(negedge clk);
        end
        cmd_ch.valid           = 1'b1;
        cmd_ch.kind            = it.kind;
        cmd_ch.hall_a_reads    = it.a_reads;
        cmd_ch.hall_b_reads    = it.b_reads;
        cmd_ch.hall_c_reads    = it.c_reads;
        cmd_ch.throttle_sample = it.throttle;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_control(input logic [HALL_READS-1:0] a, input logic [HALL_READS-1:0] b,
                                input logic [HALL_READS-1:0] c, input int unsigned throttle);
        hall_sample_t it;
        it.kind     = KIND_CONTROL;
        it.a_reads  = a;
        it.b_reads  = b;
        it.c_reads  = c;
        it.throttle = THROTTLE_W'(throttle);
        send_item(it);
    endtask

    // tick carries random hall and throttle fields, which must be ignored
    task automatic send_tick();
        hall_sample_t it;
        it.kind     = KIND_TICK;
        it.a_reads  = HALL_READS'($urandom);
        it.b_reads  = HALL_READS'($urandom);
        it.c_reads  = HALL_READS'($urandom);
        it.throttle = THROTTLE_W'($urandom);
        send_item(it);
    endtask

    // wait until every result is back and the pipeline has emptied
    task automatic drain();
        cmd_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // apb write then read back; junk above the field width must be dropped
    task automatic write_reg(input logic [1:0] idx, input int unsigned value,
                             input int unsigned width);
        logic [PDATA_W-1:0] word;
        logic [PDATA_W-1:0] readback;
        word    = PDATA_W'(value) | ($urandom << width);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        sb.write_reg(idx, word);
        if (readback !== PDATA_W'(value)) begin
            sb.mismatches++;
            $display("%0t: register %0d readback mismatch: expected %0h, actual %0h",
                     $time, idx, value, readback);
        end
    endtask

    task automatic write_settings(input int unsigned dmax, input int unsigned cutoff,
                                  input int unsigned vote, input int unsigned blank);
        write_reg(REG_DUTY_MAX, dmax, DUTY_W);
        write_reg(REG_DUTY_CUTOFF, cutoff, DUTY_W);
        write_reg(REG_VOTE_THRESHOLD, vote, VOTE_W);
        write_reg(REG_BLANK_TIME, blank, TICKS_W);
    endtask

    // sender idle / receiver stall mix per phase
    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    // forward rotation order of hall codes, one per step
    function automatic logic [2:0] code_at(int unsigned pos);
        case (pos)
            0:       return 3'd3;
            1:       return 3'd2;
            2:       return 3'd6;
            3:       return 3'd4;
            4:       return 3'd5;
            default: return 3'd1;
        endcase
    endfunction

    // reads that vote the sensor bit to the wanted value, with varied patterns
    function automatic logic [HALL_READS-1:0] reads_for(input logic want,
                                                        input logic [VOTE_W-1:0] thr);
        logic [HALL_READS-1:0] r;
        if (thr == 0)
            return HALL_READS'($urandom);
        for (int i = 0; i < 16; i++) begin
            r = HALL_READS'($urandom);
            if (($countones(r) >= thr) == want)
                return r;
        end
        return want ? '1 : '0;
    endfunction

    function automatic logic [THROTTLE_W-1:0] random_throttle();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return '1;
        else if (pick < 40)
            return THROTTLE_W'($urandom_range(600));
        return THROTTLE_W'($urandom);
    endfunction

    // mostly clean rotation with random direction changes, some invalid codes and noise
    task automatic make_random_item(output hall_sample_t it);
        int unsigned pick;
        logic [2:0]  code;
        pick        = $urandom_range(99);
        it.kind     = KIND_CONTROL;
        it.a_reads  = HALL_READS'($urandom);
        it.b_reads  = HALL_READS'($urandom);
        it.c_reads  = HALL_READS'($urandom);
        it.throttle = random_throttle();
        if (pick < 6)
            it.kind = KIND_TICK;
        else if (pick >= 14) begin
            if (pick < 20)
                code = $urandom_range(1) ? 3'd7 : 3'd0;
            else begin
                pick = $urandom_range(99);
                if (pick < 8)
                    seq_fwd = !seq_fwd;
                if (pick < 90)
                    seq_pos = seq_fwd ? (seq_pos + 1) % 6 : (seq_pos + 5) % 6;
                code = code_at(seq_pos);
            end
            it.a_reads = reads_for(code[0], sb.vote_threshold);
            it.b_reads = reads_for(code[1], sb.vote_threshold);
            it.c_reads = reads_for(code[2], sb.vote_threshold);
        end
    endtask

    // main sequence
    initial
    begin
        hall_sample_t it;
        sb                     = new();
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.kind            = KIND_CONTROL;
        cmd_ch.hall_a_reads    = '0;
        cmd_ch.hall_b_reads    = '0;
        cmd_ch.hall_c_reads    = '0;
        cmd_ch.throttle_sample = '0;
        res_ch.ready           = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        quiet_cycles           = 0;
        seq_pos                = 0;
        seq_fwd                = 1'b1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed items on reset register values
        send_control(3'b111, 3'b111, 3'b000, 0);     // same step as reset, duty zero
        send_control(3'b000, 3'b111, 3'b000, 4095);  // full throttle, step change
        send_control(3'b000, 3'b111, 3'b111, 2047);  // mid throttle
        send_control(3'b000, 3'b000, 3'b111, 102);   // rounds to the cutoff, forced off
        send_control(3'b111, 3'b000, 3'b111, 103);   // just above the cutoff
        send_control(3'b111, 3'b000, 3'b000, 4094);
        send_control(3'b111, 3'b000, 3'b000, 1);     // no step change
        send_control(3'b000, 3'b000, 3'b000, 2048);  // invalid code, all off
        send_control(3'b111, 3'b111, 3'b111, 4000);  // other invalid code, no change
        send_tick();
        send_tick();                                 // empty interval
        send_control(3'b001, 3'b010, 3'b000, 3000);  // one high read is enough
        send_control(3'b100, 3'b000, 3'b000, 1500);
        send_control(3'b110, 3'b000, 3'b011, 500);   // reverse rotation
        send_control(3'b000, 3'b000, 3'b101, 2500);
        send_control(3'b000, 3'b110, 3'b010, 3500);
        send_control(3'b000, 3'b100, 3'b000, 81);
        send_control(3'b011, 3'b101, 3'b000, 4095);
        send_tick();

        // random phases, each with its own register setting and one of four idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0:       write_settings(100, 2, 1, 5);
                1:       write_settings(127, 0, 3, 65535);
                2:       write_settings(0, 127, 0, 0);
                3:       write_settings(50, 49, 2, 1);
                4:       write_settings(75, 10, 3, 300);
                6:       write_settings(99, 98, 2, 65534);
                default: write_settings($urandom_range(127), $urandom_range(30),
                                        $urandom_range(3, 1), $urandom_range(65535));
            endcase
            set_idling(ph % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                make_random_item(it);
                send_item(it);
            end
        end

        // burst of alternating step changes within one interval
        drain();
        write_settings(100, 2, 1, 7);
        set_idling(0);
        send_tick();
        for (int n = 0; n < BURST_ITEMS; n++)
            send_control(n[0] ? 3'b000 : 3'b111, 3'b111, 3'b000, $urandom_range(4095));
        send_tick();
        send_tick();

        drain();
        repeat (8) @(negedge clk);
        $display("run covered %0d items (%0d ticks, %0d step changes), %0d results checked",
                 sb.items_noted, sb.ticks_noted, sb.changes_noted, sb.results_checked);
        $display("nine register settings over four idling mixes and a step change burst,"
                 , " %0d mismatches", sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("hall_six_step_commutator_unit_tb: PASS");
        else
            $display("hall_six_step_commutator_unit_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hssc_pkg.sv
rtl/core/hssc_if.sv
rtl/core/hall_six_step_commutator_unit.sv
dv/hall_six_step_commutator_unit_tb.sv
